FILE: hdl/spbe_pkg.sv
package spbe_pkg;

    localparam int POS_BITS = 12;
    localparam int WIN_BITS = 16;
    localparam int TIME_BITS = 32;
    localparam int BTN_BITS = 4;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // register indexes (byte address 4*i)
    localparam logic [2:0] REG_LIMIT_DOWN = 3'd0;
    localparam logic [2:0] REG_LIMIT_UP = 3'd1;
    localparam logic [2:0] REG_LIMIT_LEFT = 3'd2;
    localparam logic [2:0] REG_LIMIT_RIGHT = 3'd3;
    localparam logic [2:0] REG_DOUBLE_WINDOW = 3'd4;

    localparam logic [POS_BITS-1:0] LIMIT_DOWN_RST = POS_BITS'(3000);
    localparam logic [POS_BITS-1:0] LIMIT_UP_RST = POS_BITS'(1000);
    localparam logic [POS_BITS-1:0] LIMIT_LEFT_RST = POS_BITS'(2000);
    localparam logic [POS_BITS-1:0] LIMIT_RIGHT_RST = POS_BITS'(1300);
    localparam logic [WIN_BITS-1:0] DOUBLE_WINDOW_RST = WIN_BITS'(400);

    localparam logic [1:0] MODE_GRID = 2'd0;
    localparam logic [1:0] MODE_SEQ = 2'd1;
    localparam logic [1:0] MODE_HANDBRAKE = 2'd2;

    localparam logic [BTN_BITS-1:0] BTN_UP_LEFT = 4'd0;
    localparam logic [BTN_BITS-1:0] BTN_DOWN_LEFT = 4'd1;
    localparam logic [BTN_BITS-1:0] BTN_UP_MID = 4'd2;
    localparam logic [BTN_BITS-1:0] BTN_DOWN_MID = 4'd3;
    localparam logic [BTN_BITS-1:0] BTN_UP_RIGHT = 4'd4;
    localparam logic [BTN_BITS-1:0] BTN_DOWN_RIGHT_HI = 4'd5;
    localparam logic [BTN_BITS-1:0] BTN_DOWN_RIGHT_LO = 4'd6;
    localparam logic [BTN_BITS-1:0] BTN_SEQ_UP = 4'd7;
    localparam logic [BTN_BITS-1:0] BTN_SEQ_DOWN = 4'd8;
    localparam logic [BTN_BITS-1:0] BTN_HANDBRAKE = 4'd9;

    typedef struct packed {
        logic [POS_BITS-1:0]  horiz_pos;
        logic [POS_BITS-1:0]  vert_pos;
        logic                 push_level;
        logic [TIME_BITS-1:0] now_ms;
    } in_beat_t;

    typedef struct packed {
        logic                is_press;
        logic [BTN_BITS-1:0] button_num;
        logic                last;
    } out_beat_t;

    typedef struct packed {
        logic [POS_BITS-1:0] limit_down;
        logic [POS_BITS-1:0] limit_up;
        logic [POS_BITS-1:0] limit_left;
        logic [POS_BITS-1:0] limit_right;
        logic [WIN_BITS-1:0] double_window_ms;
    } cfg_t;

    // events produced by one sample
    typedef struct packed {
        logic [1:0] count;
        out_beat_t  ev0;
        out_beat_t  ev1;
    } ev_pair_t;

endpackage

FILE: hdl/shifter_position_to_button_events_unit.sv
// Shifter lever samples to gamepad button press/release events.
// Input channel (in_valid/in_stall/in_data): one beat per sample, taken at an
// edge with in_valid high and in_stall low. Output channel (out_valid/
// out_stall/out_data): one beat per event; last marks the final event of a
// sample. A sample gives zero, one or two events (release old, press new).
// A sample passes through the input register and then loads into the event
// queue, which drives the output; the next waits while two events remain.
// Throughput: one sample per cycle when it yields at most one event and the
// receiver does not stall; a sample loads into the two-entry event queue only
// when the queue is empty or its last beat leaves in that cycle.
// When the receiver stalls, the queue holds its events, the input register
// fills and in_stall rises; nothing is dropped.
// Limits and the double-press window sit on an APB port at byte address 4*i;
// write them only while the block is idle.
// Reset (rst_n low, async) restores the default limits, gear grid mode, no
// held button, and empties both register stages.
module shifter_position_to_button_events_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  spbe_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output spbe_pkg::out_beat_t             out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spbe_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [spbe_pkg::DATA_BITS-1:0]  pwdata,
    output logic [spbe_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready
);

    spbe_pkg::cfg_t      cfg;
    spbe_pkg::in_beat_t  in_data_reg;
    logic                in_valid_reg;
    spbe_pkg::ev_pair_t  events;
    logic                room;
    logic                process;

    assign process = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    spbe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spbe_ctl u_ctl (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .sample (in_data_reg),
        .commit (process),
        .events (events)
    );

    spbe_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (process),
        .events    (events),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: hdl/spbe_cfg.sv
module spbe_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spbe_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [spbe_pkg::DATA_BITS-1:0]      pwdata,
    output logic [spbe_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready,
    output spbe_pkg::cfg_t                      cfg
);

    spbe_pkg::cfg_t cfg_reg;
    spbe_pkg::cfg_t cfg_next;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx = paddr[spbe_pkg::ADDR_BITS-1:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                spbe_pkg::REG_LIMIT_DOWN:
                    cfg_next.limit_down = pwdata[spbe_pkg::POS_BITS-1:0];
                spbe_pkg::REG_LIMIT_UP:
                    cfg_next.limit_up = pwdata[spbe_pkg::POS_BITS-1:0];
                spbe_pkg::REG_LIMIT_LEFT:
                    cfg_next.limit_left = pwdata[spbe_pkg::POS_BITS-1:0];
                spbe_pkg::REG_LIMIT_RIGHT:
                    cfg_next.limit_right = pwdata[spbe_pkg::POS_BITS-1:0];
                spbe_pkg::REG_DOUBLE_WINDOW:
                    cfg_next.double_window_ms = pwdata[spbe_pkg::WIN_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            spbe_pkg::REG_LIMIT_DOWN:
                prdata = spbe_pkg::DATA_BITS'(cfg_reg.limit_down);
            spbe_pkg::REG_LIMIT_UP:
                prdata = spbe_pkg::DATA_BITS'(cfg_reg.limit_up);
            spbe_pkg::REG_LIMIT_LEFT:
                prdata = spbe_pkg::DATA_BITS'(cfg_reg.limit_left);
            spbe_pkg::REG_LIMIT_RIGHT:
                prdata = spbe_pkg::DATA_BITS'(cfg_reg.limit_right);
            spbe_pkg::REG_DOUBLE_WINDOW:
                prdata = spbe_pkg::DATA_BITS'(cfg_reg.double_window_ms);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.limit_down <= spbe_pkg::LIMIT_DOWN_RST;
            cfg_reg.limit_up <= spbe_pkg::LIMIT_UP_RST;
            cfg_reg.limit_left <= spbe_pkg::LIMIT_LEFT_RST;
            cfg_reg.limit_right <= spbe_pkg::LIMIT_RIGHT_RST;
            cfg_reg.double_window_ms <= spbe_pkg::DOUBLE_WINDOW_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/spbe_ctl.sv
module spbe_ctl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spbe_pkg::cfg_t       cfg,
    input  spbe_pkg::in_beat_t   sample,
    input  logic                 commit,
    output spbe_pkg::ev_pair_t   events
);

    logic [1:0]                          mode_reg, mode_next;
    logic                                prev_level_reg;
    logic [spbe_pkg::TIME_BITS-1:0]      first_press_time_reg, first_press_time_next;
    logic                                awaiting_second_reg, awaiting_second_next;
    logic                                held_valid_reg, held_valid_next;
    logic [spbe_pkg::BTN_BITS-1:0]       held_button_reg, held_button_next;

    logic                                rise;
    logic [spbe_pkg::TIME_BITS-1:0]      diff;
    logic                                in_window;
    logic                                is_up, is_down, is_left, is_right;
    logic                                keep;
    logic                                new_valid;
    logic [spbe_pkg::BTN_BITS-1:0]       new_btn;
    logic                                change;
    spbe_pkg::out_beat_t                 rel_ev, press_ev;

    assign rise = sample.push_level && !prev_level_reg;
    assign diff = sample.now_ms - first_press_time_reg;
    assign in_window = diff <= spbe_pkg::TIME_BITS'(cfg.double_window_ms);

    always_comb
    begin
        mode_next = mode_reg;
        first_press_time_next = first_press_time_reg;
        awaiting_second_next = awaiting_second_reg;
        if (rise && awaiting_second_reg)
        begin
            if (in_window)
            begin
                case (mode_reg)
                    spbe_pkg::MODE_GRID: mode_next = spbe_pkg::MODE_SEQ;
                    spbe_pkg::MODE_SEQ:  mode_next = spbe_pkg::MODE_HANDBRAKE;
                    default:             mode_next = spbe_pkg::MODE_GRID;
                endcase
            end
            else
            begin
                awaiting_second_next = 1'b0;
            end
        end
        else if (rise)
        begin
            // window opens now, so it cannot have passed
            first_press_time_next = sample.now_ms;
            awaiting_second_next = 1'b1;
        end
        else if (awaiting_second_reg && !in_window)
        begin
            awaiting_second_next = 1'b0;
        end
    end

    assign is_up = sample.vert_pos < cfg.limit_up;
    assign is_down = sample.vert_pos > cfg.limit_down;
    assign is_left = sample.horiz_pos > cfg.limit_left;
    assign is_right = sample.horiz_pos < cfg.limit_right;

    always_comb
    begin
        keep = 1'b0;
        new_valid = 1'b0;
        new_btn = '0;
        if (is_up)
        begin
            case (mode_next)
                spbe_pkg::MODE_GRID:
                begin
                    new_valid = 1'b1;
                    new_btn = is_left ? spbe_pkg::BTN_UP_LEFT :
                              is_right ? spbe_pkg::BTN_UP_RIGHT : spbe_pkg::BTN_UP_MID;
                end
                spbe_pkg::MODE_SEQ:
                begin
                    new_valid = 1'b1;
                    new_btn = spbe_pkg::BTN_SEQ_UP;
                end
                default:
                    keep = 1'b1;
            endcase
        end
        else if (is_down)
        begin
            new_valid = 1'b1;
            case (mode_next)
                spbe_pkg::MODE_GRID:
                begin
                    if (is_left)
                        new_btn = spbe_pkg::BTN_DOWN_LEFT;
                    else if (is_right)
                        new_btn = sample.push_level ? spbe_pkg::BTN_DOWN_RIGHT_HI
                                                    : spbe_pkg::BTN_DOWN_RIGHT_LO;
                    else
                        new_btn = spbe_pkg::BTN_DOWN_MID;
                end
                spbe_pkg::MODE_SEQ:
                    new_btn = spbe_pkg::BTN_SEQ_DOWN;
                default:
                    new_btn = spbe_pkg::BTN_HANDBRAKE;
            endcase
        end
    end

    assign change = !keep && ((new_valid != held_valid_reg) ||
                              (new_valid && (new_btn != held_button_reg)));

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_button_next = held_button_reg;
        if (change)
        begin
            held_valid_next = new_valid;
            held_button_next = new_btn;
        end
    end

    always_comb
    begin
        rel_ev.is_press = 1'b0;
        rel_ev.button_num = held_button_reg;
        rel_ev.last = !new_valid;
        press_ev.is_press = 1'b1;
        press_ev.button_num = new_btn;
        press_ev.last = 1'b1;

        events.ev0 = press_ev;
        events.ev1 = press_ev;
        events.count = 2'd0;
        if (change)
        begin
            if (held_valid_reg)
            begin
                events.ev0 = rel_ev;
                events.count = new_valid ? 2'd2 : 2'd1;
            end
            else
            begin
                events.count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= spbe_pkg::MODE_GRID;
            prev_level_reg <= 1'b0;
            first_press_time_reg <= '0;
            awaiting_second_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            held_button_reg <= '0;
        end
        else if (commit)
        begin
            mode_reg <= mode_next;
            prev_level_reg <= sample.push_level;
            first_press_time_reg <= first_press_time_next;
            awaiting_second_reg <= awaiting_second_next;
            held_valid_reg <= held_valid_next;
            held_button_reg <= held_button_next;
        end
    end

endmodule

FILE: hdl/spbe_evq.sv
module spbe_evq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  spbe_pkg::ev_pair_t   events,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output spbe_pkg::out_beat_t  out_data
);

    logic [1:0]           cnt_reg, cnt_next;
    spbe_pkg::out_beat_t  q0_reg, q0_next;
    spbe_pkg::out_beat_t  q1_reg, q1_next;
    logic                 pop;

    assign out_valid = cnt_reg != 2'd0;
    assign out_data = q0_reg;
    assign pop = out_valid && !out_stall;
    // a new sample may load only into an empty queue or one whose last beat leaves now
    assign room = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    always_comb
    begin
        cnt_next = cnt_reg;
        q0_next = q0_reg;
        q1_next = q1_reg;
        if (push)
        begin
            cnt_next = events.count;
            q0_next = events.ev0;
            q1_next = events.ev1;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
            q0_next = q1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

FILE: test/tb_shifter_position_to_button_events_unit.sv
`timescale 1ns / 1ps

// Tracks lever state the way the block should and keeps the button events still owed.
class shift_event_board;
    logic [spbe_pkg::POS_BITS-1:0]  lim_down;
    logic [spbe_pkg::POS_BITS-1:0]  lim_up;
    logic [spbe_pkg::POS_BITS-1:0]  lim_left;
    logic [spbe_pkg::POS_BITS-1:0]  lim_right;
    logic [spbe_pkg::WIN_BITS-1:0]  window;
    logic [1:0]                     mode;
    logic                           prev_level;
    logic                           awaiting;
    logic [spbe_pkg::TIME_BITS-1:0] first_press;
    logic                           held_valid;
    logic [spbe_pkg::BTN_BITS-1:0]  held_btn;
    spbe_pkg::out_beat_t            events[$];
    int                             errors;
    int                             checked;

    function new();
        lim_down = spbe_pkg::LIMIT_DOWN_RST;
        lim_up = spbe_pkg::LIMIT_UP_RST;
        lim_left = spbe_pkg::LIMIT_LEFT_RST;
        lim_right = spbe_pkg::LIMIT_RIGHT_RST;
        window = spbe_pkg::DOUBLE_WINDOW_RST;
        mode = spbe_pkg::MODE_GRID;
        prev_level = 1'b0;
        awaiting = 1'b0;
        first_press = '0;
        held_valid = 1'b0;
        held_btn = '0;
        errors = 0;
        checked = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [spbe_pkg::DATA_BITS-1:0] value);
        case (idx)
            spbe_pkg::REG_LIMIT_DOWN:    lim_down = value[spbe_pkg::POS_BITS-1:0];
            spbe_pkg::REG_LIMIT_UP:      lim_up = value[spbe_pkg::POS_BITS-1:0];
            spbe_pkg::REG_LIMIT_LEFT:    lim_left = value[spbe_pkg::POS_BITS-1:0];
            spbe_pkg::REG_LIMIT_RIGHT:   lim_right = value[spbe_pkg::POS_BITS-1:0];
            spbe_pkg::REG_DOUBLE_WINDOW: window = value[spbe_pkg::WIN_BITS-1:0];
            default: ;
        endcase
    endfunction

    function void note_sample(spbe_pkg::in_beat_t s);
        logic [spbe_pkg::TIME_BITS-1:0] elapsed;
        logic                           keep;
        logic                           want_valid;
        logic [spbe_pkg::BTN_BITS-1:0]  want_btn;
        spbe_pkg::out_beat_t            ev;
        keep = 1'b0;
        want_valid = 1'b0;
        want_btn = '0;

        elapsed = s.now_ms - first_press;
        if (s.push_level && !prev_level)
        begin
            if (!awaiting)
            begin
                first_press = s.now_ms;
                awaiting = 1'b1;
            end
            else if (elapsed <= spbe_pkg::TIME_BITS'(window))
            begin
                mode = (mode == spbe_pkg::MODE_GRID) ? spbe_pkg::MODE_SEQ :
                       (mode == spbe_pkg::MODE_SEQ) ? spbe_pkg::MODE_HANDBRAKE :
                       spbe_pkg::MODE_GRID;
            end
        end
        // wrapped difference, re-taken after a possible first press
        elapsed = s.now_ms - first_press;
        if (awaiting && elapsed > spbe_pkg::TIME_BITS'(window))
            awaiting = 1'b0;
        prev_level = s.push_level;

        if (s.vert_pos < lim_up)
        begin
            if (mode == spbe_pkg::MODE_GRID)
            begin
                want_valid = 1'b1;
                want_btn = (s.horiz_pos > lim_left) ? spbe_pkg::BTN_UP_LEFT :
                           (s.horiz_pos < lim_right) ? spbe_pkg::BTN_UP_RIGHT :
                           spbe_pkg::BTN_UP_MID;
            end
            else if (mode == spbe_pkg::MODE_SEQ)
            begin
                want_valid = 1'b1;
                want_btn = spbe_pkg::BTN_SEQ_UP;
            end
            else
            begin
                keep = 1'b1;    // handbrake: lever up leaves the held button alone
            end
        end
        else if (s.vert_pos > lim_down)
        begin
            want_valid = 1'b1;
            if (mode == spbe_pkg::MODE_GRID)
                want_btn = (s.horiz_pos > lim_left) ? spbe_pkg::BTN_DOWN_LEFT :
                           (s.horiz_pos < lim_right) ?
                           (s.push_level ? spbe_pkg::BTN_DOWN_RIGHT_HI
                                         : spbe_pkg::BTN_DOWN_RIGHT_LO) :
                           spbe_pkg::BTN_DOWN_MID;
            else if (mode == spbe_pkg::MODE_SEQ)
                want_btn = spbe_pkg::BTN_SEQ_DOWN;
            else
                want_btn = spbe_pkg::BTN_HANDBRAKE;
        end

        if (keep || (want_valid == held_valid && (!want_valid || want_btn == held_btn)))
            return;
        if (held_valid)
        begin
            ev.is_press = 1'b0;
            ev.button_num = held_btn;
            ev.last = !want_valid;
            events.push_back(ev);
        end
        held_valid = want_valid;
        held_btn = want_valid ? want_btn : '0;
        if (want_valid)
        begin
            ev.is_press = 1'b1;
            ev.button_num = want_btn;
            ev.last = 1'b1;
            events.push_back(ev);
        end
    endfunction

    function void check_event(spbe_pkg::out_beat_t got);
        spbe_pkg::out_beat_t want;
        if (events.size() == 0)
        begin
            $display("%0t: expected no event, got press %0b button %0d last %0b",
                     $time, got.is_press, got.button_num, got.last);
            errors++;
            return;
        end
        want = events.pop_front();
        checked++;
        if (got.is_press !== want.is_press)
        begin
            $display("%0t: is_press expected %0b got %0b", $time, want.is_press, got.is_press);
            errors++;
        end
        if (got.button_num !== want.button_num)
        begin
            $display("%0t: button_num expected %0d got %0d",
                     $time, want.button_num, got.button_num);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
            errors++;
        end
    endfunction

    function int pending();
        return events.size();
    endfunction
endclass

module tb_shifter_position_to_button_events_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 6;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    spbe_pkg::in_beat_t             in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    spbe_pkg::out_beat_t            out_data;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [spbe_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [spbe_pkg::DATA_BITS-1:0] pwdata = '0;
    logic [spbe_pkg::DATA_BITS-1:0] prdata;
    logic                           pready;

    shift_event_board               board = new();
    logic                           idle_on = 1'b1;
    int                             hold_req = 0;
    int                             hold_seen = 0;
    int                             hold_left = 0;
    int                             cycles = 0;
    int                             samples = 0;
    logic                           lvl = 1'b0;
    logic [spbe_pkg::TIME_BITS-1:0] clock_ms = '0;

    shifter_position_to_button_events_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_shifter_position_to_button_events_unit NOT OK");
            $finish;
        end
    end

    // event sink: checks each beat, stalls at random or for a long hold on request
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_event(out_data);
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= idle_on && ($urandom_range(99) < 11);
        end
    end

    function automatic spbe_pkg::in_beat_t lever_sample(
        input logic [spbe_pkg::POS_BITS-1:0]  h,
        input logic [spbe_pkg::POS_BITS-1:0]  v,
        input logic                           l,
        input logic [spbe_pkg::TIME_BITS-1:0] t);
        spbe_pkg::in_beat_t s;
        s.horiz_pos = h;
        s.vert_pos = v;
        s.push_level = l;
        s.now_ms = t;
        return s;
    endfunction

    // position around a pair of limits: anywhere, beyond either one, right on it, or between
    function automatic logic [spbe_pkg::POS_BITS-1:0] pick_pos(
        input logic [spbe_pkg::POS_BITS-1:0] below,
        input logic [spbe_pkg::POS_BITS-1:0] above);
        logic [spbe_pkg::POS_BITS-1:0] lo;
        logic [spbe_pkg::POS_BITS-1:0] hi;
        lo = (below < above) ? below : above;
        hi = (below < above) ? above : below;
        case ($urandom_range(7))
            0:       return spbe_pkg::POS_BITS'($urandom_range(4095));
            1, 2:    return (below == '0) ? '0 :
                            spbe_pkg::POS_BITS'($urandom_range(below - 1));
            3, 4:    return (above == '1) ? '1 :
                            spbe_pkg::POS_BITS'($urandom_range(4095, above + 1));
            5:       return below;
            6:       return above;
            default: return spbe_pkg::POS_BITS'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic send_sample(input spbe_pkg::in_beat_t s);
        int gap;
        gap = (idle_on && $urandom_range(99) < 11) ? $urandom_range(4, 1) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        do @(posedge clk); while (in_stall);
        board.note_sample(s);
        samples++;
    endtask

    task automatic apb_write(input logic [2:0] idx,
                             input logic [spbe_pkg::DATA_BITS-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= spbe_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_register(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(input logic [spbe_pkg::POS_BITS-1:0] down,
                           input logic [spbe_pkg::POS_BITS-1:0] up,
                           input logic [spbe_pkg::POS_BITS-1:0] left,
                           input logic [spbe_pkg::POS_BITS-1:0] right,
                           input logic [spbe_pkg::WIN_BITS-1:0] win);
        apb_write(spbe_pkg::REG_LIMIT_DOWN, spbe_pkg::DATA_BITS'(down));
        apb_write(spbe_pkg::REG_LIMIT_UP, spbe_pkg::DATA_BITS'(up));
        apb_write(spbe_pkg::REG_LIMIT_LEFT, spbe_pkg::DATA_BITS'(left));
        apb_write(spbe_pkg::REG_LIMIT_RIGHT, spbe_pkg::DATA_BITS'(right));
        apb_write(spbe_pkg::REG_DOUBLE_WINDOW, spbe_pkg::DATA_BITS'(win));
    endtask

    // samples may give no event, so let the pipeline empty before touching registers
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [spbe_pkg::TIME_BITS-1:0] tm;
        tm = 32'h0000_1000;
        send_sample(lever_sample(1500, 2000, 1'b0, tm));
        send_sample(lever_sample(4095, 0, 1'b0, tm + 10));
        send_sample(lever_sample(0, 0, 1'b0, tm + 20));
        send_sample(lever_sample(1500, 0, 1'b0, tm + 30));
        send_sample(lever_sample(4095, 4095, 1'b0, tm + 40));
        send_sample(lever_sample(1500, 4095, 1'b0, tm + 50));
        send_sample(lever_sample(0, 4095, 1'b0, tm + 60));
        send_sample(lever_sample(0, 4095, 1'b1, tm + 70));
        send_sample(lever_sample(1500, 2000, 1'b0, tm + 90));
        send_sample(lever_sample(1500, 0, 1'b1, tm + 100));
        send_sample(lever_sample(1500, 4095, 1'b0, tm + 110));
        tm = tm + 2000;
        send_sample(lever_sample(1500, 4095, 1'b0, tm));
        send_sample(lever_sample(1500, 4095, 1'b1, tm + 10));
        send_sample(lever_sample(1500, 4095, 1'b0, tm + 20));
        // second press exactly at the window edge still counts
        send_sample(lever_sample(1500, 0, 1'b1, tm + 410));
        send_sample(lever_sample(1500, 4095, 1'b0, tm + 420));
        send_sample(lever_sample(1500, 0, 1'b0, tm + 430));
        send_sample(lever_sample(1500, 2000, 1'b0, tm + 2000));
        // double press across the 32-bit time wrap
        send_sample(lever_sample(1500, 2000, 1'b1, 32'hFFFF_FFF0));
        send_sample(lever_sample(4095, 0, 1'b0, 32'hFFFF_FFF8));
        send_sample(lever_sample(4095, 0, 1'b1, 32'h0000_0010));
        send_sample(lever_sample(0, 4095, 1'b0, 32'h0000_1000));
        send_sample(lever_sample(0, 4095, 1'b1, 32'h0000_1010));
        send_sample(lever_sample(0, 4095, 1'b0, 32'h0000_1020));
        send_sample(lever_sample(0, 4095, 1'b1, 32'h0000_11A3));
        clock_ms = 32'h0000_2000;
    endtask

    task automatic run_random(input int count);
        spbe_pkg::in_beat_t            s;
        logic [spbe_pkg::WIN_BITS-1:0] win;
        for (int k = 0; k < count; k++)
        begin
            win = board.window;
            case ($urandom_range(19))
                0:       clock_ms = $urandom();
                1:       clock_ms = 32'hFFFF_FFFF - $urandom_range(300);
                2:       clock_ms = board.first_press + spbe_pkg::TIME_BITS'(win);
                3:       clock_ms = board.first_press + spbe_pkg::TIME_BITS'(win) + 32'd1;
                4, 5:    ;
                default: clock_ms = clock_ms + $urandom_range(win / 2 + 20);
            endcase
            if ($urandom_range(2) == 0)
                lvl = ~lvl;
            s.horiz_pos = pick_pos(board.lim_right, board.lim_left);
            s.vert_pos = pick_pos(board.lim_up, board.lim_down);
            s.push_level = lvl;
            s.now_ms = clock_ms;
            send_sample(s);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(100);
        drain();

        set_all('0, '0, '0, '0, '0);
        run_random(100);
        drain();

        // maximum limits, no idling on either side
        idle_on <= 1'b0;
        set_all('1, '1, '1, '1, '1);
        run_random(100);
        drain();
        idle_on <= 1'b1;

        // overlapping limits; sink holds off so the input side backs up
        set_all(12'd1000, 12'd3000, 12'd1500, 12'd2500, 16'd150);
        hold_req <= hold_req + 1;
        run_random(100);
        drain();

        set_all(spbe_pkg::POS_BITS'($urandom_range(4095)),
                spbe_pkg::POS_BITS'($urandom_range(4095)),
                spbe_pkg::POS_BITS'($urandom_range(4095)),
                spbe_pkg::POS_BITS'($urandom_range(4095)),
                spbe_pkg::WIN_BITS'($urandom_range(1000)));
        run_random(100);
        drain();

        apb_write(REG_UNUSED, '1);
        set_all(spbe_pkg::LIMIT_DOWN_RST, spbe_pkg::LIMIT_UP_RST, spbe_pkg::LIMIT_LEFT_RST,
                spbe_pkg::LIMIT_RIGHT_RST, spbe_pkg::DOUBLE_WINDOW_RST);
        run_random(100);
        drain();

        $display("%0d lever samples over six limit/window settings, %0d button events checked",
                 samples, board.checked);
        $display("%0d mismatches", board.errors);
        if (board.errors == 0)
            $display("tb_shifter_position_to_button_events_unit OK");
        else
            $display("tb_shifter_position_to_button_events_unit NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/spbe_pkg.sv
hdl/spbe_cfg.sv
hdl/spbe_ctl.sv
hdl/spbe_evq.sv
hdl/shifter_position_to_button_events_unit.sv
test/tb_shifter_position_to_button_events_unit.sv
